// ===== rtl/um32_pkg.sv =====
// Shared constants and types for the UM-32 machine core.
package um32_pkg;

  localparam int unsigned SegCount = 16;
  localparam int unsigned SegWords = 1024;
  localparam int unsigned IdW = $clog2(SegCount);
  localparam int unsigned OffW = $clog2(SegWords);
  localparam int unsigned LenW = OffW + 1;
  localparam int unsigned CntW = IdW + 1;
  localparam int unsigned AddrW = IdW + OffW;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [3:0] OP_CMOV = 4'd0;
  localparam logic [3:0] OP_INDEX = 4'd1;
  localparam logic [3:0] OP_AMEND = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_NAND = 4'd6;
  localparam logic [3:0] OP_HALT = 4'd7;
  localparam logic [3:0] OP_ALLOC = 4'd8;
  localparam logic [3:0] OP_FREE = 4'd9;
  localparam logic [3:0] OP_OUT = 4'd10;
  localparam logic [3:0] OP_IN = 4'd11;
  localparam logic [3:0] OP_LOADP = 4'd12;
  localparam logic [3:0] OP_ORTH = 4'd13;

  typedef logic [31:0] word_t;

endpackage

// ===== rtl/um32_machine_core.sv =====
// UM-32 machine core: sequencer, register file, segment memory and a shared divider.
// Steps: load writes through S_LOADW; a simple step runs S_FETCH, S_FWAIT and S_EXEC, array index
// adds a data memory read in S_RDW; divide adds S_DIV (one quotient bit per cycle in a shared
// shift-subtract unit); alloc zeroes one word per cycle and load program copies word by word.
// One transaction at a time; the next is accepted only once the result is taken.
// Reset (rst, synchronous) clears registers, lengths and ids; segment memory not cleared.
module um32_machine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] program_word,
  input  logic [7:0]  in_char,
  output logic        out_valid_q,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        in_consumed,
  output logic [1:0]  status,
  output logic [9:0]  pc_now
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_FWAIT = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_RDW   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ZERO  = 4'd6;
  localparam logic [3:0] S_CPRD  = 4'd7;
  localparam logic [3:0] S_CPWR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_LOADW = 4'd10;

  logic [3:0] state;

  um32_pkg::word_t regs [8];
  um32_pkg::word_t mem [2**um32_pkg::AddrW];
  logic [um32_pkg::LenW-1:0] seg_length [um32_pkg::SegCount];
  logic [um32_pkg::SegCount-1:0] seg_live;
  logic [um32_pkg::IdW-1:0] free_stack [um32_pkg::SegCount];
  logic [um32_pkg::CntW-1:0] free_count;
  logic [um32_pkg::CntW-1:0] next_fresh_id;
  logic halted;
  logic [um32_pkg::LenW-1:0] prog_counter;

  // memory port
  logic mem_we;
  logic [um32_pkg::AddrW-1:0] mem_addr;
  um32_pkg::word_t mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  um32_pkg::word_t instr;
  logic [7:0] char_q;
  logic [3:0] opc;
  logic [2:0] ra, rb, rc;
  um32_pkg::word_t va, vb, vc;
  assign opc = instr[31:28];
  assign ra = instr[8:6];
  assign rb = instr[5:3];
  assign rc = instr[2:0];
  assign va = regs[ra];
  assign vb = regs[rb];
  assign vc = regs[rc];

  // divider and walk registers
  um32_pkg::word_t quo, rem_q;
  logic [5:0] div_cnt;
  logic [32:0] rem_try;
  assign rem_try = {rem_q, quo[31]} - {1'b0, vc};

  logic [um32_pkg::IdW-1:0] walk_id;
  logic [um32_pkg::LenW-1:0] walk_i, walk_n;

  // decoded checks
  logic b_seg_ok, a_seg_ok, c_seg_ok, b_seg_ok12;
  logic [um32_pkg::IdW-1:0] b_id, a_id, c_id;
  assign b_id = vb[um32_pkg::IdW-1:0];
  assign a_id = va[um32_pkg::IdW-1:0];
  assign c_id = vc[um32_pkg::IdW-1:0];
  assign b_seg_ok = (vb < 32'(um32_pkg::SegCount)) && seg_live[b_id];
  assign a_seg_ok = (va < 32'(um32_pkg::SegCount)) && seg_live[a_id];
  assign c_seg_ok = (vc < 32'(um32_pkg::SegCount)) && seg_live[c_id];
  assign b_seg_ok12 = b_seg_ok;

  logic idx_ok, amd_ok;
  assign idx_ok = b_seg_ok && (vc < 32'(seg_length[b_id]));
  assign amd_ok = a_seg_ok && (vb < 32'(seg_length[a_id]));

  assign in_ready = (state == S_IDLE) && !out_valid_q;

  logic [1:0] st_r;
  logic ov_r, ic_r;
  logic [7:0] oc_r;

  always_comb begin
    mem_we = 1'b0;
    mem_addr = '0;
    mem_wdata = '0;
    unique case (state)
      S_IDLE: begin
        mem_addr = {{um32_pkg::IdW{1'b0}}, prog_counter[um32_pkg::OffW-1:0]};
      end
      S_LOADW: begin
        mem_we = 1'b1;
        mem_addr = {{um32_pkg::IdW{1'b0}}, seg_length[0][um32_pkg::OffW-1:0]};
        mem_wdata = instr;
      end
      S_FETCH, S_FWAIT: begin
        mem_addr = {{um32_pkg::IdW{1'b0}}, prog_counter[um32_pkg::OffW-1:0]};
      end
      S_EXEC: begin
        if (opc == um32_pkg::OP_AMEND) begin
          mem_addr = {a_id, vb[um32_pkg::OffW-1:0]};
          mem_wdata = vc;
          mem_we = amd_ok;
        end else begin
          mem_addr = {b_id, vc[um32_pkg::OffW-1:0]};
        end
      end
      S_RDW: mem_addr = {b_id, vc[um32_pkg::OffW-1:0]};
      S_ZERO: begin
        mem_we = 1'b1;
        mem_addr = {walk_id, walk_i[um32_pkg::OffW-1:0]};
      end
      S_CPRD: mem_addr = {walk_id, walk_i[um32_pkg::OffW-1:0]};
      S_CPWR: begin
        mem_we = 1'b1;
        mem_addr = {{um32_pkg::IdW{1'b0}}, walk_i[um32_pkg::OffW-1:0]};
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      for (int i = 0; i < int'(um32_pkg::SegCount); i++) seg_length[i] <= '0;
      seg_live <= {{(um32_pkg::SegCount-1){1'b0}}, 1'b1};
      free_count <= '0;
      next_fresh_id <= um32_pkg::CntW'(1);
      halted <= 1'b0;
      prog_counter <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            instr <= program_word;
            char_q <= in_char;
            ov_r <= 1'b0; ic_r <= 1'b0; oc_r <= '0; st_r <= um32_pkg::ST_OK;
            if (!op) begin
              if (seg_length[0] >= um32_pkg::LenW'(um32_pkg::SegWords)) begin
                st_r <= um32_pkg::ST_FAULT;
                state <= S_DONE;
              end else state <= S_LOADW;
            end else if (halted) begin
              st_r <= um32_pkg::ST_HALT;
              state <= S_DONE;
            end else if (prog_counter >= seg_length[0]) begin
              st_r <= um32_pkg::ST_FAULT;
              state <= S_DONE;
            end else state <= S_FETCH;
          end
        end
        S_LOADW: begin
          seg_length[0] <= seg_length[0] + 1'b1;
          state <= S_DONE;
        end
        S_FETCH: state <= S_FWAIT;
        S_FWAIT: begin
          instr <= mem_rdata;
          prog_counter <= prog_counter + 1'b1;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (opc)
            um32_pkg::OP_CMOV: if (vc != 0) regs[ra] <= vb;
            um32_pkg::OP_INDEX: begin
              if (idx_ok) state <= S_RDW;
              else st_r <= um32_pkg::ST_FAULT;
            end
            um32_pkg::OP_AMEND: if (!amd_ok) st_r <= um32_pkg::ST_FAULT;
            um32_pkg::OP_ADD: regs[ra] <= vb + vc;
            um32_pkg::OP_MUL: regs[ra] <= vb * vc;
            um32_pkg::OP_DIV: begin
              if (vc == 0) st_r <= um32_pkg::ST_FAULT;
              else begin
                quo <= vb; rem_q <= '0; div_cnt <= '0;
                state <= S_DIV;
              end
            end
            um32_pkg::OP_NAND: regs[ra] <= ~(vb & vc);
            um32_pkg::OP_HALT: begin
              halted <= 1'b1;
              st_r <= um32_pkg::ST_HALT;
            end
            um32_pkg::OP_ALLOC: begin
              if (vc > 32'(um32_pkg::SegWords)) st_r <= um32_pkg::ST_FAULT;
              else if (free_count != 0) begin
                walk_id <= free_stack[free_count[um32_pkg::IdW-1:0] - 1'b1];
                free_count <= free_count - 1'b1;
                walk_n <= vc[um32_pkg::LenW-1:0];
                walk_i <= '0;
                state <= S_ZERO;
              end else if (next_fresh_id < um32_pkg::CntW'(um32_pkg::SegCount)) begin
                walk_id <= next_fresh_id[um32_pkg::IdW-1:0];
                next_fresh_id <= next_fresh_id + 1'b1;
                walk_n <= vc[um32_pkg::LenW-1:0];
                walk_i <= '0;
                state <= S_ZERO;
              end else st_r <= um32_pkg::ST_FAULT;
            end
            um32_pkg::OP_FREE: begin
              if (vc == 0 || !c_seg_ok) st_r <= um32_pkg::ST_FAULT;
              else begin
                seg_live[c_id] <= 1'b0;
                seg_length[c_id] <= '0;
                if (free_count < um32_pkg::CntW'(um32_pkg::SegCount)) begin
                  free_stack[free_count[um32_pkg::IdW-1:0]] <= c_id;
                  free_count <= free_count + 1'b1;
                end
              end
            end
            um32_pkg::OP_OUT: begin
              ov_r <= 1'b1;
              oc_r <= vc[7:0];
            end
            um32_pkg::OP_IN: begin
              regs[rc] <= {24'd0, char_q};
              ic_r <= 1'b1;
            end
            um32_pkg::OP_LOADP: begin
              if (vc >= 32'(um32_pkg::SegWords)) st_r <= um32_pkg::ST_FAULT;
              else if (vb != 0 && !b_seg_ok12) st_r <= um32_pkg::ST_FAULT;
              else begin
                prog_counter <= vc[um32_pkg::LenW-1:0];
                if (vb != 0) begin
                  walk_id <= b_id;
                  walk_n <= seg_length[b_id];
                  walk_i <= '0;
                  seg_length[0] <= seg_length[b_id];
                  state <= (seg_length[b_id] == 0) ? S_DONE : S_CPRD;
                end
              end
            end
            um32_pkg::OP_ORTH: regs[instr[27:25]] <= {7'd0, instr[24:0]};
            default: st_r <= um32_pkg::ST_SKIP;
          endcase
        end
        S_RDW: begin
          regs[ra] <= mem_rdata;
          state <= S_DONE;
        end
        S_DIV: begin
          // one quotient bit a cycle, restoring
          if (!rem_try[32]) rem_q <= rem_try[31:0];
          else rem_q <= {rem_q[30:0], quo[31]};
          quo <= {quo[30:0], !rem_try[32]};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd31) begin
            regs[ra] <= {quo[30:0], !rem_try[32]};
            state <= S_DONE;
          end
        end
        S_ZERO: begin
          if (walk_i >= walk_n) begin
            seg_length[walk_id] <= walk_n;
            seg_live[walk_id] <= 1'b1;
            regs[rb] <= 32'(walk_id);
            state <= S_DONE;
          end else walk_i <= walk_i + 1'b1;
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          walk_i <= walk_i + 1'b1;
          state <= (walk_i + 1'b1 >= walk_n) ? S_DONE : S_CPRD;
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          out_valid <= ov_r;
          out_char <= oc_r;
          in_consumed <= ic_r;
          status <= st_r;
          pc_now <= prog_counter[9:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_um32_machine_core.sv =====
// Self-checking testbench for the UM-32 machine core: random and directed programs.
module tb_um32_machine_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_char;
    logic       in_consumed;
    logic [1:0] status;
    logic [9:0] pc_now;
  } um_result_t;

  class um_scoreboard;
    bit [31:0]   gpr[8];
    int unsigned pc;
    bit [31:0]   mem[um32_pkg::SegCount * um32_pkg::SegWords];
    int unsigned seg_len[um32_pkg::SegCount];
    bit          seg_live[um32_pkg::SegCount];
    int unsigned free_ids[um32_pkg::SegCount];
    int unsigned free_cnt;
    int unsigned fresh_id;
    bit          halted;
    um_result_t  expected_q[$];
    int          errors;
    int          n_loads, n_steps, n_results;
    int          n_status[4];

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (seg_len[i]) seg_len[i] = 0;
      foreach (seg_live[i]) seg_live[i] = 0;
      seg_live[0] = 1;
      pc = 0;
      free_cnt = 0;
      fresh_id = 1;
      halted = 0;
      errors = 0;
    endfunction

    function bit seg_ok(bit [31:0] id);
      return id < um32_pkg::SegCount && seg_live[id];
    endfunction

    function logic [1:0] run_instr(bit [31:0] ins, bit [7:0] ch, inout um_result_t r);
      bit [3:0]    opc;
      int unsigned a, b, c, id, n;
      opc = ins[31:28];
      a = int'(ins[8:6]);
      b = int'(ins[5:3]);
      c = int'(ins[2:0]);
      case (opc)
        um32_pkg::OP_CMOV: if (gpr[c] != 0) gpr[a] = gpr[b];
        um32_pkg::OP_INDEX: begin
          if (!seg_ok(gpr[b]) || gpr[c] >= seg_len[gpr[b]]) return um32_pkg::ST_FAULT;
          gpr[a] = mem[gpr[b] * um32_pkg::SegWords + gpr[c]];
        end
        um32_pkg::OP_AMEND: begin
          if (!seg_ok(gpr[a]) || gpr[b] >= seg_len[gpr[a]]) return um32_pkg::ST_FAULT;
          mem[gpr[a] * um32_pkg::SegWords + gpr[b]] = gpr[c];
        end
        um32_pkg::OP_ADD: gpr[a] = gpr[b] + gpr[c];
        um32_pkg::OP_MUL: gpr[a] = gpr[b] * gpr[c];
        um32_pkg::OP_DIV: begin
          if (gpr[c] == 0) return um32_pkg::ST_FAULT;
          gpr[a] = gpr[b] / gpr[c];
        end
        um32_pkg::OP_NAND: gpr[a] = ~(gpr[b] & gpr[c]);
        um32_pkg::OP_HALT: begin
          halted = 1;
          return um32_pkg::ST_HALT;
        end
        um32_pkg::OP_ALLOC: begin
          if (gpr[c] > um32_pkg::SegWords) return um32_pkg::ST_FAULT;
          n = gpr[c];
          if (free_cnt > 0) begin
            free_cnt--;
            id = free_ids[free_cnt];
          end else if (fresh_id < um32_pkg::SegCount) begin
            id = fresh_id;
            fresh_id++;
          end else begin
            return um32_pkg::ST_FAULT;
          end
          for (int i = 0; i < n; i++) mem[id * um32_pkg::SegWords + i] = '0;
          seg_len[id] = n;
          seg_live[id] = 1;
          gpr[b] = id;
        end
        um32_pkg::OP_FREE: begin
          if (gpr[c] == 0 || !seg_ok(gpr[c])) return um32_pkg::ST_FAULT;
          id = gpr[c];
          seg_live[id] = 0;
          seg_len[id] = 0;
          if (free_cnt < um32_pkg::SegCount) begin
            free_ids[free_cnt] = id;
            free_cnt++;
          end
        end
        um32_pkg::OP_OUT: begin
          r.out_valid = 1;
          r.out_char = gpr[c][7:0];
        end
        um32_pkg::OP_IN: begin
          gpr[c] = {24'd0, ch};
          r.in_consumed = 1;
        end
        um32_pkg::OP_LOADP: begin
          if (gpr[c] >= um32_pkg::SegWords) return um32_pkg::ST_FAULT;
          if (gpr[b] != 0) begin
            if (!seg_ok(gpr[b])) return um32_pkg::ST_FAULT;
            n = seg_len[gpr[b]];
            for (int i = 0; i < n; i++) mem[i] = mem[gpr[b] * um32_pkg::SegWords + i];
            seg_len[0] = n;
          end
          pc = gpr[c];
        end
        um32_pkg::OP_ORTH: gpr[ins[27:25]] = {7'd0, ins[24:0]};
        default: return um32_pkg::ST_SKIP;
      endcase
      return um32_pkg::ST_OK;
    endfunction

    // Work out the result of one accepted transaction and queue it.
    function void note_item(bit opv, bit [31:0] word, bit [7:0] ch);
      um_result_t r;
      bit [31:0]  ins;
      r = '0;
      r.status = um32_pkg::ST_OK;
      if (!opv) begin
        n_loads++;
        if (seg_len[0] >= um32_pkg::SegWords) r.status = um32_pkg::ST_FAULT;
        else begin
          mem[seg_len[0]] = word;
          seg_len[0]++;
        end
      end else begin
        n_steps++;
        if (halted) r.status = um32_pkg::ST_HALT;
        else if (pc >= seg_len[0]) r.status = um32_pkg::ST_FAULT;
        else begin
          ins = mem[pc];
          pc++;
          r.status = run_instr(ins, ch, r);
        end
      end
      r.pc_now = pc[9:0];
      n_status[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(um_result_t got);
      um_result_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.out_valid !== e.out_valid) begin
        $display("%0t: out_valid exp %0d got %0d", $realtime, e.out_valid, got.out_valid);
        errors++;
      end
      if (got.out_char !== e.out_char) begin
        $display("%0t: out_char exp %h got %h", $realtime, e.out_char, got.out_char);
        errors++;
      end
      if (got.in_consumed !== e.in_consumed) begin
        $display("%0t: in_consumed exp %0d got %0d", $realtime, e.in_consumed,
                 got.in_consumed);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
        errors++;
      end
      if (got.pc_now !== e.pc_now) begin
        $display("%0t: pc_now exp %0d got %0d", $realtime, e.pc_now, got.pc_now);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        op = 0;
  logic [31:0] program_word = '0;
  logic [7:0]  in_char = '0;
  logic        out_valid_q;
  logic        out_ready = 0;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        in_consumed;
  logic [1:0]  status;
  logic [9:0]  pc_now;

  um_scoreboard machine_sb = new();
  bit           quiet = 0;
  int           ready_hold = 0;

  um32_machine_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .program_word(program_word), .in_char(in_char), .out_valid_q(out_valid_q),
    .out_ready(out_ready), .out_valid(out_valid), .out_char(out_char),
    .in_consumed(in_consumed), .status(status), .pc_now(pc_now)
  );

  always #5 clk = ~clk;

  function automatic bit [31:0] instr(bit [3:0] opc, int a, int b, int c);
    return {opc, 19'd0, 3'(a), 3'(b), 3'(c)};
  endfunction

  function automatic bit [31:0] orth(int r, int v);
    return {um32_pkg::OP_ORTH, 3'(r), 25'(v)};
  endfunction

  // Mostly sensible instructions on small values; never a halt.
  function automatic bit [31:0] random_instr();
    bit [31:0] w;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return orth($urandom_range(0, 7), $urandom_range(0, 20));
    if (pick < 35) return orth($urandom_range(0, 7), $urandom);
    if (pick < 45) begin
      w = $urandom;
      if (w[31:28] == um32_pkg::OP_HALT) w[31:28] = um32_pkg::OP_ADD;
      return w;
    end
    w = $urandom;
    w[31:28] = 4'($urandom_range(0, 15));
    if (w[31:28] == um32_pkg::OP_HALT) w[31:28] = um32_pkg::OP_NAND;
    w[27:9] = '0;
    return w;
  endfunction

  // Present one transaction at the falling edge and hold it until taken.
  task automatic send_item(bit opv, bit [31:0] word);
    int gap;
    @(negedge clk);
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    op = opv;
    program_word = opv ? $urandom : word;
    in_char = 8'($urandom);
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    machine_sb.note_item(op, program_word, in_char);
  endtask

  task automatic load_words(bit [31:0] words[$]);
    foreach (words[i]) send_item(1'b0, words[i]);
  endtask

  task automatic step_n(int n);
    repeat (n) send_item(1'b1, '0);
  endtask

  // Wait until every queued result has been checked.
  task automatic drain();
    while (machine_sb.expected_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      ready_hold <= $urandom_range(0, 11);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid_q && out_ready)
      machine_sb.check_result({out_valid, out_char, in_consumed, status, pc_now});
  end

  initial begin
    #50ms;
    $display("um32_machine_core regression: fail");
    $finish;
  end

  initial begin
    bit [31:0] prog[$];
    int        k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Bad pc on an empty program, then arithmetic, segments and I/O.
    step_n(1);
    prog = '{orth(1, 25'h1ffffff), orth(2, 3), instr(um32_pkg::OP_ADD, 3, 1, 2),
             instr(um32_pkg::OP_MUL, 4, 1, 1), instr(um32_pkg::OP_DIV, 5, 1, 2),
             instr(um32_pkg::OP_DIV, 5, 1, 0), instr(um32_pkg::OP_NAND, 6, 1, 2),
             instr(um32_pkg::OP_CMOV, 7, 1, 2), instr(um32_pkg::OP_CMOV, 7, 2, 0),
             orth(2, 1024), instr(um32_pkg::OP_ALLOC, 0, 3, 2),
             instr(um32_pkg::OP_AMEND, 3, 0, 1), instr(um32_pkg::OP_INDEX, 4, 3, 0),
             instr(um32_pkg::OP_INDEX, 4, 3, 2), instr(um32_pkg::OP_LOADP, 0, 0, 2),
             orth(2, 1025), instr(um32_pkg::OP_ALLOC, 0, 5, 2),
             instr(um32_pkg::OP_OUT, 0, 0, 1), instr(um32_pkg::OP_IN, 0, 0, 6),
             instr(um32_pkg::OP_FREE, 0, 0, 0), 32'he0000000, 32'hf1234567,
             instr(um32_pkg::OP_FREE, 0, 0, 3), instr(um32_pkg::OP_FREE, 0, 0, 3)};
    load_words(prog);
    step_n(prog.size() + 1);

    // Let every result drain before carrying on.
    @(negedge clk);
    in_valid = 0;
    drain();

    // Random programs, loaded in bursts and then run.
    while (machine_sb.n_loads + machine_sb.n_steps < 500) begin
      if (machine_sb.n_loads + machine_sb.n_steps > 430) quiet = 1;
      k = $urandom_range(3, 16);
      for (int i = 0; i < k; i++) send_item(1'b0, random_instr());
      step_n(k + $urandom_range(0, 3));
    end

    // Fill segment 0 through a program load, then halt.
    prog = '{orth(2, 1024), instr(um32_pkg::OP_ALLOC, 0, 3, 2), orth(1, 25'h700000),
             orth(2, 25'h100), instr(um32_pkg::OP_MUL, 1, 1, 2), orth(2, 1),
             instr(um32_pkg::OP_AMEND, 3, 2, 1), orth(0, 0),
             instr(um32_pkg::OP_LOADP, 0, 3, 0)};
    load_words(prog);
    step_n(20);
    send_item(1'b0, $urandom);
    step_n(3);
    send_item(1'b0, $urandom);
    @(negedge clk);
    in_valid = 0;

    drain();
    repeat (3000) @(posedge clk);
    $display("Ran %0d loads and %0d steps; %0d results checked.", machine_sb.n_loads,
             machine_sb.n_steps, machine_sb.n_results);
    $display("Status counts ok/halt/skip/fault: %0d/%0d/%0d/%0d", machine_sb.n_status[0],
             machine_sb.n_status[1], machine_sb.n_status[2], machine_sb.n_status[3]);
    if (machine_sb.errors == 0 && machine_sb.expected_q.size() == 0)
      $display("um32_machine_core regression: pass");
    else
      $display("um32_machine_core regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/um32_pkg.sv
rtl/um32_machine_core.sv
bench/tb_um32_machine_core.sv
